[rtl/core/ttae_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, reset values and register map for the two-tap echo core.
// No dependencies.
package ttae_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 15;
    localparam int DLY_W    = 14;
    localparam int PROD_W   = 32;
    localparam int ACC_W    = 34;
    localparam int FRAC_W   = 15;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam int DELAY_DEPTH_DEF = 16384;

    // reciprocal scaling used to fold a delay into a short delay memory
    localparam int RECIP_SHIFT = 28;

    // bias added to negative sums so the shift truncates toward zero
    localparam int TRUNC_BIAS = (1 << FRAC_W) - 1;

    localparam logic [GAIN_W-1:0] GAIN_DIRECT_RST      = GAIN_W'(16384);
    localparam logic [GAIN_W-1:0] GAIN_FIRST_ECHO_RST  = GAIN_W'(9830);
    localparam logic [GAIN_W-1:0] GAIN_SECOND_ECHO_RST = GAIN_W'(6554);
    localparam logic [DLY_W-1:0]  DELAY_FIRST_RST      = DLY_W'(7999);
    localparam logic [DLY_W-1:0]  DELAY_SECOND_RST     = DLY_W'(11999);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GAIN_DIRECT      = 3'd0,
        REG_GAIN_FIRST_ECHO  = 3'd1,
        REG_GAIN_SECOND_ECHO = 3'd2,
        REG_DELAY_FIRST      = 3'd3,
        REG_DELAY_SECOND     = 3'd4
    } t_reg_idx;

endpackage

[rtl/core/two_tap_audio_echo_core.sv]
`timescale 1ns / 1ps
// Two-tap feedforward comb echo: circular delay memory, three unsigned Q0.15 taps.
// Depends on ttae_pkg.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_sample_in  (s16)
//  out     | output    | o_out_valid / i_out_stall  | o_sample_out (s16)
//  cfg     | input     | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One item per cycle sustained while the output is not stalled; each item is registered
// in every stage in turn. The rate is set by the delay memory: one write and two reads per cycle.
// Six pipeline stages (A, B, C, D, E, output) each hold one item; an output stall
// holds only the stages that are full, so o_in_stall rises only when all six are.
// Reset clears control state; a wrap flag on the write pointer stands in for
// clearing the memory, so the block takes items from the first cycle after reset.
module two_tap_audio_echo_core #(
    parameter int DELAY_DEPTH = ttae_pkg::DELAY_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [ttae_pkg::SAMPLE_W-1:0]  i_sample_in,

    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [ttae_pkg::SAMPLE_W-1:0]  o_sample_out,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ttae_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [ttae_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [ttae_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    localparam int AW    = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam bit SMALL = DELAY_DEPTH < (2 ** ttae_pkg::DLY_W);

    // ---------------- configuration registers ----------------
    logic [ttae_pkg::GAIN_W-1:0] r_gain_direct;
    logic [ttae_pkg::GAIN_W-1:0] r_gain_first_echo;
    logic [ttae_pkg::GAIN_W-1:0] r_gain_second_echo;
    logic [ttae_pkg::DLY_W-1:0]  r_delay_first;
    logic [ttae_pkg::DLY_W-1:0]  r_delay_second;

    ttae_pkg::t_reg_idx          reg_idx;
    logic                        cfg_wr;

    assign reg_idx = ttae_pkg::t_reg_idx'(paddr[ttae_pkg::APB_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_direct      <= ttae_pkg::GAIN_DIRECT_RST;
            r_gain_first_echo  <= ttae_pkg::GAIN_FIRST_ECHO_RST;
            r_gain_second_echo <= ttae_pkg::GAIN_SECOND_ECHO_RST;
            r_delay_first      <= ttae_pkg::DELAY_FIRST_RST;
            r_delay_second     <= ttae_pkg::DELAY_SECOND_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                ttae_pkg::REG_GAIN_DIRECT: begin
                    r_gain_direct <= pwdata[ttae_pkg::GAIN_W-1:0];
                end
                ttae_pkg::REG_GAIN_FIRST_ECHO: begin
                    r_gain_first_echo <= pwdata[ttae_pkg::GAIN_W-1:0];
                end
                ttae_pkg::REG_GAIN_SECOND_ECHO: begin
                    r_gain_second_echo <= pwdata[ttae_pkg::GAIN_W-1:0];
                end
                ttae_pkg::REG_DELAY_FIRST: begin
                    r_delay_first <= pwdata[ttae_pkg::DLY_W-1:0];
                end
                ttae_pkg::REG_DELAY_SECOND: begin
                    r_delay_second <= pwdata[ttae_pkg::DLY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ttae_pkg::REG_GAIN_DIRECT:      prdata = ttae_pkg::APB_DATA_W'(r_gain_direct);
            ttae_pkg::REG_GAIN_FIRST_ECHO:  prdata = ttae_pkg::APB_DATA_W'(r_gain_first_echo);
            ttae_pkg::REG_GAIN_SECOND_ECHO: prdata = ttae_pkg::APB_DATA_W'(r_gain_second_echo);
            ttae_pkg::REG_DELAY_FIRST:      prdata = ttae_pkg::APB_DATA_W'(r_delay_first);
            ttae_pkg::REG_DELAY_SECOND:     prdata = ttae_pkg::APB_DATA_W'(r_delay_second);
            default:                        prdata = '0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_o_vld;
    logic ld_a, ld_b, ld_c, ld_d, ld_e, ld_o;
    logic mem_we;

    // a stage may load when empty or when its item moves on this cycle
    assign ld_o = !r_o_vld || !i_out_stall;
    assign ld_e = !r_e_vld || ld_o;
    assign ld_d = !r_d_vld || ld_e;
    assign ld_c = !r_c_vld || ld_d;
    assign ld_b = !r_b_vld || ld_c;
    assign ld_a = !r_a_vld || ld_b;

    assign o_in_stall  = !ld_a;
    assign mem_we      = r_b_vld && ld_c;
    assign o_out_valid = r_o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (ld_a) r_a_vld <= i_in_valid;
            if (ld_b) r_b_vld <= r_a_vld;
            if (ld_c) r_c_vld <= r_b_vld;
            if (ld_d) r_d_vld <= r_c_vld;
            if (ld_e) r_e_vld <= r_d_vld;
            if (ld_o) r_o_vld <= r_e_vld;
        end
    end

    // ---------------- stage A: capture sample and delays ----------------
    logic signed [ttae_pkg::SAMPLE_W-1:0] r_a_x;
    logic [ttae_pkg::DLY_W-1:0]           r_a_d1;
    logic [ttae_pkg::DLY_W-1:0]           r_a_d2;

    always_ff @(posedge i_clk) begin
        if (ld_a) begin
            r_a_x  <= i_sample_in;
            r_a_d1 <= r_delay_first;
            r_a_d2 <= r_delay_second;
        end
    end

    // ---------------- stage B: delays folded into memory depth ----------------
    logic signed [ttae_pkg::SAMPLE_W-1:0] r_b_x;
    logic [AW-1:0]                        r_b_red1;
    logic [AW-1:0]                        r_b_red2;
    logic [AW-1:0]                        n_b_red1;
    logic [AW-1:0]                        n_b_red2;

    generate
        if (SMALL) begin : g_fold
            localparam int PW    = ttae_pkg::DLY_W + ttae_pkg::RECIP_SHIFT;
            localparam int QW    = 2 * ttae_pkg::DLY_W;
            localparam int RECIP = (2 ** ttae_pkg::RECIP_SHIFT) / DELAY_DEPTH;

            logic [ttae_pkg::DLY_W-1:0] r_a_q1;
            logic [ttae_pkg::DLY_W-1:0] r_a_q2;
            logic [PW-1:0]              prod1;
            logic [PW-1:0]              prod2;
            logic [ttae_pkg::DLY_W-1:0] qd1;
            logic [ttae_pkg::DLY_W-1:0] qd2;
            logic [ttae_pkg::DLY_W-1:0] rem1;
            logic [ttae_pkg::DLY_W-1:0] rem2;

            // quotient estimate, at most one below the true quotient
            assign prod1 = PW'(r_delay_first) * PW'(RECIP);
            assign prod2 = PW'(r_delay_second) * PW'(RECIP);

            always_ff @(posedge i_clk) begin
                if (ld_a) begin
                    r_a_q1 <= prod1[PW-1:ttae_pkg::RECIP_SHIFT];
                    r_a_q2 <= prod2[PW-1:ttae_pkg::RECIP_SHIFT];
                end
            end

            always_comb begin
                qd1  = ttae_pkg::DLY_W'(QW'(r_a_q1) * QW'(DELAY_DEPTH));
                qd2  = ttae_pkg::DLY_W'(QW'(r_a_q2) * QW'(DELAY_DEPTH));
                rem1 = r_a_d1 - qd1;
                rem2 = r_a_d2 - qd2;
                // correct a low quotient estimate
                if (rem1 >= ttae_pkg::DLY_W'(DELAY_DEPTH)) begin
                    rem1 = rem1 - ttae_pkg::DLY_W'(DELAY_DEPTH);
                end
                if (rem2 >= ttae_pkg::DLY_W'(DELAY_DEPTH)) begin
                    rem2 = rem2 - ttae_pkg::DLY_W'(DELAY_DEPTH);
                end
                n_b_red1 = AW'(rem1);
                n_b_red2 = AW'(rem2);
            end
        end else begin : g_nofold
            assign n_b_red1 = AW'(r_a_d1);
            assign n_b_red2 = AW'(r_a_d2);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (ld_b) begin
            r_b_x    <= r_a_x;
            r_b_red1 <= n_b_red1;
            r_b_red2 <= n_b_red2;
        end
    end

    // ---------------- delay memory: write current, read both taps ----------------
    logic [AW-1:0] r_wp;
    logic          r_wrapped;
    logic [AW-1:0] rd_addr1;
    logic [AW-1:0] rd_addr2;
    logic          tap_ok1;
    logic          tap_ok2;

    logic [ttae_pkg::SAMPLE_W-1:0] mem [DELAY_DEPTH];

    // an entry behind the write pointer is live; one ahead only after a wrap
    always_comb begin
        if (r_b_red1 <= r_wp) begin
            rd_addr1 = r_wp - r_b_red1;
            tap_ok1  = 1'b1;
        end else begin
            rd_addr1 = AW'((AW+1)'(r_wp) + (AW+1)'(DELAY_DEPTH) - (AW+1)'(r_b_red1));
            tap_ok1  = r_wrapped;
        end
        if (r_b_red2 <= r_wp) begin
            rd_addr2 = r_wp - r_b_red2;
            tap_ok2  = 1'b1;
        end else begin
            rd_addr2 = AW'((AW+1)'(r_wp) + (AW+1)'(DELAY_DEPTH) - (AW+1)'(r_b_red2));
            tap_ok2  = r_wrapped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
        end else if (mem_we) begin
            if (r_wp == AW'(DELAY_DEPTH - 1)) begin
                r_wp      <= '0;
                r_wrapped <= 1'b1;
            end else begin
                r_wp <= r_wp + 1'b1;
            end
        end
    end

    logic signed [ttae_pkg::SAMPLE_W-1:0] r_c_x;
    logic signed [ttae_pkg::SAMPLE_W-1:0] r_c_rd1;
    logic signed [ttae_pkg::SAMPLE_W-1:0] r_c_rd2;
    logic                                 r_c_byp1;
    logic                                 r_c_byp2;
    logic                                 r_c_ok1;
    logic                                 r_c_ok2;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wp] <= r_b_x;
        end
        if (ld_c) begin
            r_c_rd1 <= mem[rd_addr1];
            r_c_rd2 <= mem[rd_addr2];
        end
    end

    // a zero delay reads the entry written in the same cycle: take the sample directly
    always_ff @(posedge i_clk) begin
        if (ld_c) begin
            r_c_x    <= r_b_x;
            r_c_byp1 <= (r_b_red1 == '0);
            r_c_byp2 <= (r_b_red2 == '0);
            r_c_ok1  <= tap_ok1;
            r_c_ok2  <= tap_ok2;
        end
    end

    // ---------------- stage D: three products ----------------
    logic signed [ttae_pkg::SAMPLE_W-1:0] tap1;
    logic signed [ttae_pkg::SAMPLE_W-1:0] tap2;
    logic signed [ttae_pkg::SAMPLE_W:0]   g0;
    logic signed [ttae_pkg::SAMPLE_W:0]   g1;
    logic signed [ttae_pkg::SAMPLE_W:0]   g2;
    logic signed [ttae_pkg::PROD_W-1:0]   r_d_p0;
    logic signed [ttae_pkg::PROD_W-1:0]   r_d_p1;
    logic signed [ttae_pkg::PROD_W-1:0]   r_d_p2;

    always_comb begin
        tap1 = r_c_byp1 ? r_c_x : (r_c_ok1 ? r_c_rd1 : '0);
        tap2 = r_c_byp2 ? r_c_x : (r_c_ok2 ? r_c_rd2 : '0);
        g0   = $signed({2'b00, r_gain_direct});
        g1   = $signed({2'b00, r_gain_first_echo});
        g2   = $signed({2'b00, r_gain_second_echo});
    end

    always_ff @(posedge i_clk) begin
        if (ld_d) begin
            r_d_p0 <= ttae_pkg::PROD_W'(r_c_x * g0);
            r_d_p1 <= ttae_pkg::PROD_W'(tap1 * g1);
            r_d_p2 <= ttae_pkg::PROD_W'(tap2 * g2);
        end
    end

    // ---------------- stage E: sum ----------------
    logic signed [ttae_pkg::ACC_W-1:0] r_e_acc;

    always_ff @(posedge i_clk) begin
        if (ld_e) begin
            r_e_acc <= ttae_pkg::ACC_W'(r_d_p0) + ttae_pkg::ACC_W'(r_d_p1)
                     + ttae_pkg::ACC_W'(r_d_p2);
        end
    end

    // ---------------- output: truncate toward zero, saturate ----------------
    logic signed [ttae_pkg::ACC_W-1:0]    bias;
    logic signed [ttae_pkg::ACC_W-1:0]    scaled;
    logic                                 sat_hi;
    logic                                 sat_lo;
    logic signed [ttae_pkg::SAMPLE_W-1:0] n_o_sample;
    logic signed [ttae_pkg::SAMPLE_W-1:0] r_o_sample;

    always_comb begin
        bias = '0;
        if (r_e_acc[ttae_pkg::ACC_W-1]) begin
            bias = ttae_pkg::ACC_W'(ttae_pkg::TRUNC_BIAS);
        end
        scaled = (r_e_acc + bias) >>> ttae_pkg::FRAC_W;
        sat_hi = !scaled[ttae_pkg::ACC_W-1]
              && (|scaled[ttae_pkg::ACC_W-2:ttae_pkg::SAMPLE_W-1]);
        sat_lo = scaled[ttae_pkg::ACC_W-1]
              && !(&scaled[ttae_pkg::ACC_W-2:ttae_pkg::SAMPLE_W-1]);
        if (sat_hi) begin
            n_o_sample = {1'b0, {(ttae_pkg::SAMPLE_W-1){1'b1}}};
        end else if (sat_lo) begin
            n_o_sample = {1'b1, {(ttae_pkg::SAMPLE_W-1){1'b0}}};
        end else begin
            n_o_sample = scaled[ttae_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_o) begin
            r_o_sample <= n_o_sample;
        end
    end

    assign o_sample_out = r_o_sample;

`ifndef SYNTHESIS
    // input backs up only when the whole pipeline is full and the output is held
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && r_a_vld && r_b_vld
                        && r_c_vld && r_d_vld && r_e_vld))
        else $error("input stalled with an empty stage");

    // folded delays stay inside the memory
    a_fold_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld |-> (((AW+1)'(r_b_red1) < (AW+1)'(DELAY_DEPTH))
                  && ((AW+1)'(r_b_red2) < (AW+1)'(DELAY_DEPTH))))
        else $error("folded delay beyond memory depth");

    // write pointer wraps to zero at the last entry and marks the memory as filled
    a_wp_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && (r_wp == AW'(DELAY_DEPTH - 1))) |=> ((r_wp == '0) && r_wrapped))
        else $error("write pointer wrap broken");

    // once filled, the memory stays filled until reset
    a_wrapped_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wrapped |=> r_wrapped)
        else $error("fill flag dropped");

    // the pointer only moves when an item writes the memory
    a_wp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !mem_we |=> $stable(r_wp))
        else $error("write pointer moved without a write");
`endif

endmodule
